### rtl/i2crf_pkg.sv
// Package with shared types, codes and reset values of the I2C target register file.
package i2crf_pkg;

	localparam logic [1:0] REQ_ADDR_WR = 2'd0;
	localparam logic [1:0] REQ_ADDR_RD = 2'd1;
	localparam logic [1:0] REQ_DATA_RD = 2'd2;
	localparam logic [1:0] REQ_DATA_WR = 2'd3;

	localparam logic [7:0] IDX_ERROR   = 8'd0;
	localparam logic [7:0] IDX_CLEAR   = 8'd1;
	localparam logic [7:0] IDX_PER_H   = 8'd2;
	localparam logic [7:0] IDX_PER_L   = 8'd3;
	localparam logic [7:0] IDX_TIMEOUT = 8'd4;
	localparam logic [7:0] IDX_ALARM_H = 8'd5;
	localparam logic [7:0] IDX_ALARM_L = 8'd6;

	localparam logic [15:0] RST_PERIOD  = 16'h03D0;
	localparam logic [7:0]  RST_TIMEOUT = 8'd10;
	localparam logic [15:0] RST_ALARM   = 16'd1825;

	localparam logic [1:0] OP_PLAIN  = 2'd0;
	localparam logic [1:0] OP_READ   = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;
	localparam logic [1:0] OP_PERIOD = 2'd3;

	typedef struct packed {
		logic       we;
		logic [7:0] waddr;
		logic [7:0] wdata;
		logic       re;
		logic [7:0] raddr;
	} mem_cmd_t;

	function automatic logic [7:0] reset_value(input logic [7:0] addr);
		logic [7:0] v;
		case (addr)
			IDX_PER_H:   v = RST_PERIOD[15:8];
			IDX_PER_L:   v = RST_PERIOD[7:0];
			IDX_TIMEOUT: v = RST_TIMEOUT;
			IDX_ALARM_H: v = RST_ALARM[15:8];
			IDX_ALARM_L: v = RST_ALARM[7:0];
			default:     v = 8'd0;
		endcase
		return v;
	endfunction

endpackage

### rtl/i2crf_if.sv
// Handshake interfaces for bus events and result transfers.
interface i2crf_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic [7:0] data_in;

	modport source (output valid, output req_type, output data_in, input ready);
	modport sink (input valid, input req_type, input data_in, output ready);
endinterface

interface i2crf_rsp_if;
	logic        valid;
	logic        ready;
	logic [7:0]  read_data;
	logic        ack;
	logic        period_load;
	logic [15:0] period_value;

	modport source (output valid, output read_data, output ack, output period_load,
		output period_value, input ready);
	modport sink (input valid, input read_data, input ack, input period_load,
		input period_value, output ready);
endinterface

### rtl/i2c_target_register_file_unit.sv
// Top level of the I2C target register file: pointer control, result stage and output register.
// Each bus event is accepted into the result stage, and some events issue a read of the register file
// memory that the result stage then uses as registered data; no new event is taken until the last one
// has moved into the result register, and a result held by a stalled sink stalls the result stage.
// No clearing pass is needed after reset; unwritten entries read their reset values.
module i2c_target_register_file_unit #(
	parameter int REG_COUNT = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	i2crf_req_if.sink           req,
	i2crf_rsp_if.source         rsp
);
	localparam logic [7:0] COUNT = 8'(REG_COUNT);

	logic [7:0]          ptr_q, ptr_d;
	logic                loaded_q, loaded_d;
	logic                busy_s1;
	logic [1:0]          kind_s1, kind_d;
	logic                ack_s1, ack_d;
	logic [7:0]          data_s1;
	logic                out_valid_q;
	logic [7:0]          rd_q;
	logic                ack_q;
	logic                load_q;
	logic [15:0]         per_q;
	logic                accept, adv, in_rng;
	logic [7:0]          ptr_inc, rdata;
	i2crf_pkg::mem_cmd_t cmd;

	assign accept   = req.valid && req.ready;
	assign req.ready = !busy_s1;
	assign adv      = busy_s1 && (!out_valid_q || rsp.ready);
	assign in_rng   = ptr_q < COUNT;
	assign ptr_inc  = ptr_q + 8'd1;

	always_comb begin
		ptr_d    = ptr_q;
		loaded_d = loaded_q;
		kind_d   = i2crf_pkg::OP_PLAIN;
		ack_d    = 1'b1;
		cmd      = '0;
		if (accept) begin
			case (req.req_type)
				i2crf_pkg::REQ_ADDR_WR: loaded_d = 1'b0;
				i2crf_pkg::REQ_DATA_RD: begin
					if (in_rng) begin
						cmd.re    = 1'b1;
						cmd.raddr = ptr_q;
						kind_d    = i2crf_pkg::OP_READ;
						ptr_d     = ptr_inc;
					end else begin
						ack_d = 1'b0;
					end
				end
				i2crf_pkg::REQ_DATA_WR: begin
					if (!loaded_q) begin
						ptr_d    = req.data_in;
						loaded_d = 1'b1;
						ack_d    = req.data_in < COUNT;
					end else if (in_rng) begin
						cmd.we    = 1'b1;
						cmd.waddr = ptr_q;
						cmd.wdata = req.data_in;
						if (ptr_q == i2crf_pkg::IDX_CLEAR) begin
							cmd.re    = 1'b1;
							cmd.raddr = i2crf_pkg::IDX_ERROR;
							kind_d    = i2crf_pkg::OP_CLEAR;
						end else if (ptr_q == i2crf_pkg::IDX_PER_L) begin
							cmd.re    = 1'b1;
							cmd.raddr = i2crf_pkg::IDX_PER_H;
							kind_d    = i2crf_pkg::OP_PERIOD;
						end
						ptr_d = ptr_inc;
						ack_d = ptr_inc < COUNT;
					end else begin
						ack_d = 1'b0;
					end
				end
				default: ;
			endcase
		end else if (adv && kind_s1 == i2crf_pkg::OP_CLEAR) begin
			cmd.we    = 1'b1;
			cmd.waddr = i2crf_pkg::IDX_ERROR;
			cmd.wdata = rdata & ~data_s1;
		end
	end

	i2crf_mem #(
		.DEPTH(REG_COUNT)
	) u_mem (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q       <= '0;
			loaded_q    <= 1'b0;
			busy_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			ptr_q    <= ptr_d;
			loaded_q <= loaded_d;
			if (accept) begin
				busy_s1 <= 1'b1;
			end else if (adv) begin
				busy_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= kind_d;
			ack_s1  <= ack_d;
			data_s1 <= req.data_in;
		end
		if (adv) begin
			rd_q   <= (kind_s1 == i2crf_pkg::OP_READ) ? rdata : 8'd0;
			ack_q  <= ack_s1;
			load_q <= kind_s1 == i2crf_pkg::OP_PERIOD;
			per_q  <= (kind_s1 == i2crf_pkg::OP_PERIOD) ? {rdata, data_s1} : 16'd0;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.read_data    = rd_q;
	assign rsp.ack          = ack_q;
	assign rsp.period_load  = load_q;
	assign rsp.period_value = per_q;

	a_busy_from_accept: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy_s1) |-> $past(accept))
		else $error("result stage started without a transfer");

	a_loaded_from_write: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(loaded_q) |-> $past(accept && req.req_type == i2crf_pkg::REQ_DATA_WR))
		else $error("pointer loaded without a data write");

	a_load_acks: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.period_load |-> rsp.ack && rsp.read_data == 8'd0)
		else $error("period reload with bad ack or read data");

	a_read_acks: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.read_data != 8'd0 |-> rsp.ack)
		else $error("read data returned with NACK");

endmodule

### rtl/i2crf_mem.sv
// Register file memory with per-entry valid bits and reset values for unwritten entries.
module i2crf_mem #(
	parameter int DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  i2crf_pkg::mem_cmd_t cmd,
	output logic [7:0]         rdata
);
	localparam int AW = $clog2(DEPTH);

	logic [7:0]       mem_q [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [7:0]       rd_q;
	logic             rvld_q;
	logic [7:0]       raddr_q;

	always_ff @(posedge clk) begin
		if (cmd.we) begin
			mem_q[cmd.waddr[AW-1:0]] <= cmd.wdata;
		end
		if (cmd.re) begin
			rd_q    <= mem_q[cmd.raddr[AW-1:0]];
			rvld_q  <= vld_q[cmd.raddr[AW-1:0]];
			raddr_q <= cmd.raddr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (cmd.we) begin
			vld_q[cmd.waddr[AW-1:0]] <= 1'b1;
		end
	end

	assign rdata = rvld_q ? rd_q : i2crf_pkg::reset_value(raddr_q);

endmodule
